// File: src/i2crtm_pkg.sv
// Shared types, codes and helper functions of the I2C register transaction master.
package i2crtm_pkg;

    // Action codes carried on the input tuser
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Bus segment codes
    localparam logic [2:0] SEG_START     = 3'd0;
    localparam logic [2:0] SEG_WB_ADDR_W = 3'd1;
    localparam logic [2:0] SEG_WB_CMD    = 3'd2;
    localparam logic [2:0] SEG_WB_DATA   = 3'd3;
    localparam logic [2:0] SEG_WB_ADDR_R = 3'd4;
    localparam logic [2:0] SEG_RB_ACK    = 3'd5;
    localparam logic [2:0] SEG_RB_NACK   = 3'd6;
    localparam logic [2:0] SEG_STOP      = 3'd7;

    // Last plan position of each transaction kind
    localparam logic [2:0] WR_LAST_POS = 3'd4;
    localparam logic [2:0] RD_LAST_POS = 3'd7;

    // One input item
    typedef struct packed {
        logic [1:0] action;
        logic [6:0] dev_addr;
        logic [7:0] reg_cmd;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    // One result item
    typedef struct packed {
        logic        scl_level;
        logic        sda_pull_low;
        logic        busy_res;
        logic        done_res;
        logic        ack_ok;
        logic [15:0] read_data;
    } result_t;

    // Segment at a plan position
    function automatic logic [2:0] plan_seg(input logic rd, input logic [2:0] pos);
        logic [2:0] s;
        begin
            s = SEG_STOP;
            if (rd)
            begin
                case (pos)
                    3'd0:    s = SEG_START;
                    3'd1:    s = SEG_WB_ADDR_W;
                    3'd2:    s = SEG_WB_CMD;
                    3'd3:    s = SEG_START;
                    3'd4:    s = SEG_WB_ADDR_R;
                    3'd5:    s = SEG_RB_ACK;
                    3'd6:    s = SEG_RB_NACK;
                    default: s = SEG_STOP;
                endcase
            end
            else
            begin
                case (pos)
                    3'd0:    s = SEG_START;
                    3'd1:    s = SEG_WB_ADDR_W;
                    3'd2:    s = SEG_WB_CMD;
                    3'd3:    s = SEG_WB_DATA;
                    default: s = SEG_STOP;
                endcase
            end
            return s;
        end
    endfunction

    // Last phase offset inside a segment
    function automatic logic [4:0] seg_last_off(input logic [2:0] s);
        logic [4:0] r;
        begin
            case (s)
                SEG_START, SEG_STOP: r = 5'd3;
                SEG_RB_ACK:          r = 5'd19;
                SEG_RB_NACK:         r = 5'd18;
                default:             r = 5'd26;
            endcase
            return r;
        end
    endfunction

endpackage

// File: src/i2crtm_engine.sv
// Phase engine: transaction state and the per-tick pin phase logic.
module i2crtm_engine
    import i2crtm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    output result_t res
);

    logic       busy_reg,     busy_next;
    logic [2:0] pos_reg,      pos_next;
    logic [4:0] off_reg,      off_next;
    logic [1:0] ph_reg,       ph_next;
    logic [2:0] bit_idx_reg,  bit_idx_next;
    logic [7:0] shift_reg,    shift_next;
    logic [6:0] addr_reg,     addr_next;
    logic [7:0] cmd_reg,      cmd_next;
    logic [7:0] wbyte_reg,    wbyte_next;
    logic       is_read_reg,  is_read_next;
    logic       ack_reg,      ack_next;
    logic [15:0] word_reg,    word_next;
    logic       scl_reg,      scl_next;
    logic       sda_reg,      sda_next;

    logic       start;
    logic       active;
    logic       done;
    logic [2:0] seg;
    logic [7:0] tx_byte;
    logic [7:0] shifted;
    logic [2:0] last_pos;

    assign start  = !busy_reg && (item.action == ACT_WRITE || item.action == ACT_READ);
    assign active = busy_reg || start;

    // Compute the phase of this tick and the next state
    always_comb
    begin
        busy_next    = busy_reg;
        pos_next     = pos_reg;
        off_next     = off_reg;
        ph_next      = ph_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        addr_next    = addr_reg;
        cmd_next     = cmd_reg;
        wbyte_next   = wbyte_reg;
        is_read_next = is_read_reg;
        ack_next     = ack_reg;
        word_next    = word_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        done         = 1'b0;
        seg          = SEG_STOP;
        tx_byte      = 8'h00;
        shifted      = {shift_reg[6:0], item.sda_in};
        last_pos     = WR_LAST_POS;

        // Latch the transaction on the accepting tick
        if (start)
        begin
            busy_next    = 1'b1;
            pos_next     = 3'd0;
            off_next     = 5'd0;
            ph_next      = 2'd0;
            bit_idx_next = 3'd0;
            shift_next   = 8'h00;
            addr_next    = item.dev_addr;
            cmd_next     = item.reg_cmd;
            wbyte_next   = item.write_data;
            is_read_next = (item.action == ACT_READ);
            ack_next     = 1'b1;
            word_next    = 16'hFFFF;
            shifted      = {7'd0, item.sda_in};
        end

        if (active)
        begin
            seg      = plan_seg(is_read_next, pos_next);
            last_pos = is_read_next ? RD_LAST_POS : WR_LAST_POS;

            case (seg)
                SEG_WB_ADDR_W: tx_byte = {addr_next, 1'b0};
                SEG_WB_CMD:    tx_byte = cmd_next;
                SEG_WB_DATA:   tx_byte = wbyte_next;
                default:       tx_byte = {addr_next, 1'b1};
            endcase

            case (seg)
                SEG_START:
                begin
                    case (off_next[1:0])
                        2'd0:    scl_next = 1'b1;
                        2'd1:    sda_next = 1'b1;
                        2'd2:    scl_next = 1'b0;
                        default: sda_next = 1'b0;
                    endcase
                end
                SEG_STOP:
                begin
                    case (off_next[1:0])
                        2'd0:    scl_next = 1'b0;
                        2'd1:    sda_next = 1'b1;
                        2'd2:    scl_next = 1'b1;
                        default: sda_next = 1'b0;
                    endcase
                end
                SEG_RB_ACK, SEG_RB_NACK:
                begin
                    if (off_next < 5'd16)
                    begin
                        if (!off_next[0])
                        begin
                            scl_next = 1'b1;
                        end
                        else
                        begin
                            // Sample SDA as SCL falls
                            shift_next = shifted;
                            scl_next   = 1'b0;
                            if (off_next == 5'd15)
                            begin
                                if (seg == SEG_RB_ACK)
                                    word_next = {8'h00, shifted};
                                else
                                    word_next = word_next | {shifted, 8'h00};
                                shift_next = 8'h00;
                            end
                        end
                    end
                    else if (seg == SEG_RB_ACK)
                    begin
                        case (off_next[1:0])
                            2'd0:    sda_next = 1'b1;
                            2'd1:    scl_next = 1'b1;
                            2'd2:    scl_next = 1'b0;
                            default: sda_next = 1'b0;
                        endcase
                    end
                    else
                    begin
                        case (off_next[1:0])
                            2'd0:    scl_next = 1'b1;
                            2'd1:    scl_next = 1'b0;
                            default: sda_next = 1'b0;
                        endcase
                    end
                end
                default:
                begin
                    if (off_next < 5'd24)
                    begin
                        // Three phases per data bit, MSB first
                        case (ph_next)
                            2'd0:    sda_next = ~tx_byte[~bit_idx_next];
                            2'd1:    scl_next = 1'b1;
                            default: scl_next = 1'b0;
                        endcase
                        if (ph_next == 2'd2)
                        begin
                            ph_next      = 2'd0;
                            bit_idx_next = bit_idx_next + 3'd1;
                        end
                        else
                        begin
                            ph_next = ph_next + 2'd1;
                        end
                    end
                    else if (off_next == 5'd24)
                    begin
                        sda_next = 1'b0;
                    end
                    else if (off_next == 5'd25)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        // Acknowledge sample; low SDA means ACK
                        if (is_read_next)
                            ack_next = ack_next & ~item.sda_in;
                        else if (seg == SEG_WB_DATA)
                            ack_next = ~item.sda_in;
                        scl_next = 1'b0;
                    end
                end
            endcase

            // Advance through the plan
            if (off_next == seg_last_off(seg))
            begin
                off_next = 5'd0;
                if (pos_next == last_pos)
                begin
                    done      = 1'b1;
                    busy_next = 1'b0;
                    pos_next  = 3'd0;
                end
                else
                begin
                    pos_next = pos_next + 3'd1;
                end
            end
            else
            begin
                off_next = off_next + 5'd1;
            end
        end
    end

    // Result of this tick
    always_comb
    begin
        res.scl_level    = scl_next;
        res.sda_pull_low = sda_next;
        res.busy_res     = active;
        res.done_res     = done;
        res.ack_ok       = done & ack_next;
        res.read_data    = done ? word_next : 16'h0000;
    end

    // Hold state between accepted ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pos_reg     <= 3'd0;
            off_reg     <= 5'd0;
            ph_reg      <= 2'd0;
            bit_idx_reg <= 3'd0;
            shift_reg   <= 8'h00;
            addr_reg    <= 7'd0;
            cmd_reg     <= 8'h00;
            wbyte_reg   <= 8'h00;
            is_read_reg <= 1'b0;
            ack_reg     <= 1'b1;
            word_reg    <= 16'hFFFF;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b0;
        end
        else if (advance)
        begin
            busy_reg    <= busy_next;
            pos_reg     <= pos_next;
            off_reg     <= off_next;
            ph_reg      <= ph_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            addr_reg    <= addr_next;
            cmd_reg     <= cmd_next;
            wbyte_reg   <= wbyte_next;
            is_read_reg <= is_read_next;
            ack_reg     <= ack_next;
            word_reg    <= word_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

`ifndef SYNTHESIS
    // Offset stays inside the longest segment
    a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        off_reg <= 5'd26)
        else $error("segment offset out of range");

    // Idle engine rests at the plan origin
    a_idle_origin: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pos_reg == 3'd0 && off_reg == 5'd0 && ph_reg == 2'd0))
        else $error("idle engine not at plan origin");

    // Bit phase counter never reaches three
    a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg != 2'd3)
        else $error("bit phase counter out of range");
`endif

endmodule

// File: src/i2c_register_transaction_master_core.sv
// Top level of the tick-driven I2C register transaction master.
// Usage:
//   Each transfer on the s_axis channel is one bus phase tick. While the
//   master is idle, tuser selects a register byte write or a register word
//   read; the accepting tick already performs the first pin phase. A write
//   runs 89 ticks, a read 132 ticks; action codes seen while busy are ignored.
//   Every input transfer yields exactly one m_axis transfer with the SCL
//   level, the SDA pull-low, busy, acknowledge flag and read word; tlast
//   marks the tick that ends a transaction, where ack and read word are valid.
//   An input transfer reaches result valid through one input register and
//   one result register around the phase engine.
//   Throughput is one tick per cycle while the output is not stalled; the
//   engine state updates on every accepted tick, so ticks may arrive back to back.
//   When m_axis_tready is low the result register holds, the input register
//   takes one more tick, and s_axis_tready then drops until the result moves.
//   Reset leaves the master idle with SCL high and SDA released.
module i2c_register_transaction_master_core
    import i2crtm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // dev_addr[6:0], reg_cmd[14:7], write_data[22:15], sda_in[23]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // scl_level[0], sda_pull_low[1], busy_res[2], ack_ok[3],
                                        // read_data[19:4], zero[23:20]
    output logic        m_axis_tlast    // done_res
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t eng_res;
    logic    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.action     <= s_axis_tuser;
            in_item_reg.dev_addr   <= s_axis_tdata[6:0];
            in_item_reg.reg_cmd    <= s_axis_tdata[14:7];
            in_item_reg.write_data <= s_axis_tdata[22:15];
            in_item_reg.sda_in     <= s_axis_tdata[23];
        end
    end

    i2crtm_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .res     (eng_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_res_reg.done_res;
    assign m_axis_tdata  = {4'h0, out_res_reg.read_data, out_res_reg.ack_ok,
                            out_res_reg.busy_res, out_res_reg.sda_pull_low,
                            out_res_reg.scl_level};

`ifndef SYNTHESIS
    // A done tick is always a busy tick
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.done_res) |-> out_res_reg.busy_res)
        else $error("done without busy");

    // Ack and read word are zero away from done
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.done_res) |->
        (!out_res_reg.ack_ok && out_res_reg.read_data == 16'h0000))
        else $error("result fields set without done");

    // A buffered tick is never dropped while the output stalls
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("buffered tick lost");
`endif

endmodule
